// ===== hw/rtl/ssdc_pkg.sv =====
`default_nettype none

package ssdc_pkg;

	localparam int unsigned DIGITS = 4;

	function automatic int unsigned pow10(input int unsigned n);
		int unsigned p;
		p = 1;
		for (int unsigned i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	localparam int unsigned NUM_W     = 14;
	localparam int unsigned LEVEL_W   = 3;
	localparam int unsigned NUM_LIMIT = pow10(DIGITS);
	localparam int unsigned DIG_W     = 4 * DIGITS;
	localparam int unsigned NUM_BYTES = 2 * DIGITS + 3;
	localparam int unsigned IDX_W     = $clog2(NUM_BYTES);
	localparam int unsigned CNT_W     = $clog2(DIGITS + 1);
	localparam int unsigned QDEPTH    = 2;
	localparam int unsigned QP_W      = $clog2(QDEPTH);
	localparam int unsigned QC_W      = $clog2(QDEPTH + 1);

	// floor(x / 10) = (x * RECIP10) >> RECIP_SH for every 14-bit x
	localparam int unsigned RECIP_W   = 16;
	localparam int unsigned PROD_W    = NUM_W + RECIP_W;
	localparam int unsigned RECIP_SH  = 19;
	localparam logic [RECIP_W-1:0] RECIP10 = 16'd52429;

	localparam logic [7:0] CMD_MODE     = 8'h00;
	localparam logic [7:0] CMD_FIXED    = 8'h44;
	localparam logic [7:0] ADDR_BASE    = 8'hc0;
	localparam logic [7:0] ADDR_STEP    = 8'h02;
	localparam logic [7:0] CMD_DISP_ON  = 8'h88;
	localparam logic [7:0] CMD_DISP_OFF = 8'h80;

	typedef enum logic [1:0] {
		MODE_SHOW  = 2'd0,
		MODE_LEVEL = 2'd1,
		MODE_ON    = 2'd2,
		MODE_OFF   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		JOB_ERR,
		JOB_BYTE,
		JOB_NUM
	} job_kind_t;

	typedef struct packed {
		logic [NUM_W-1:0]   number;
		logic [LEVEL_W-1:0] level;
		logic               on;
	} status_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [7:0]       code;
		logic [DIG_W-1:0] digits;
		status_t          status;
	} job_t;

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssdc_req_if.sv =====
`default_nettype none

interface ssdc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [13:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssdc_rsp_if.sv =====
`default_nettype none

interface ssdc_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        frame_start;
	logic        frame_end;
	logic        last;
	logic        error;
	logic [13:0] shown_number;
	logic [2:0]  brightness;
	logic        display_enabled;

	modport source (
		output valid, output out_byte, output frame_start, output frame_end,
		output last, output error, output shown_number, output brightness,
		output display_enabled, input ready
	);
	modport sink (
		input valid, input out_byte, input frame_start, input frame_end,
		input last, input error, input shown_number, input brightness,
		input display_enabled, output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/ssdc_front.sv =====
`default_nettype none

module ssdc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ssdc_req_if.sink           req,
	input  wire logic          q_full,
	output ssdc_pkg::job_t     push_job,
	output logic               push
);

	logic                                conv_q;
	logic [ssdc_pkg::CNT_W-1:0]          cnt_q;
	logic [ssdc_pkg::NUM_W-1:0]          rest_q;
	logic [ssdc_pkg::NUM_W-1:0]          val_q;
	logic [ssdc_pkg::DIG_W-1:0]          digs_q;
	logic [ssdc_pkg::NUM_W-1:0]          num_q;
	logic [ssdc_pkg::LEVEL_W-1:0]        level_q;
	logic                                on_q;

	logic                                accept;
	logic                                cnt_done;
	ssdc_pkg::mode_t                     req_mode;
	logic                                num_bad;
	logic                                level_bad;
	logic [ssdc_pkg::PROD_W-1:0]         prod;
	logic [ssdc_pkg::NUM_W-1:0]          quot;
	logic [ssdc_pkg::NUM_W-1:0]          quot10;
	logic [ssdc_pkg::NUM_W-1:0]          rem_full;
	logic [ssdc_pkg::NUM_W-1:0]          nxt_num;
	logic [ssdc_pkg::LEVEL_W-1:0]        nxt_level;
	logic                                nxt_on;

	assign req.ready = !conv_q && !q_full;
	assign accept    = req.valid && req.ready;
	assign req_mode  = ssdc_pkg::mode_t'(req.mode);
	assign num_bad   = 32'(req.value) >= 32'(ssdc_pkg::NUM_LIMIT);
	assign level_bad = |req.value[ssdc_pkg::NUM_W-1:ssdc_pkg::LEVEL_W];
	assign cnt_done  = cnt_q == ssdc_pkg::CNT_W'(ssdc_pkg::DIGITS);

	// one decimal digit per cycle, least significant first
	assign prod     = ssdc_pkg::PROD_W'(rest_q) * ssdc_pkg::PROD_W'(ssdc_pkg::RECIP10);
	assign quot     = ssdc_pkg::NUM_W'(prod[ssdc_pkg::PROD_W-1:ssdc_pkg::RECIP_SH]);
	assign quot10   = (quot << 3) + (quot << 1);
	assign rem_full = rest_q - quot10;

	always_comb begin
		push             = 1'b0;
		nxt_num          = num_q;
		nxt_level        = level_q;
		nxt_on           = on_q;
		push_job.kind    = ssdc_pkg::JOB_BYTE;
		push_job.code    = ssdc_pkg::CMD_DISP_ON;
		push_job.digits  = digs_q;
		if (conv_q) begin
			if (cnt_done && !q_full) begin
				push          = 1'b1;
				push_job.kind = ssdc_pkg::JOB_NUM;
				nxt_num       = val_q;
				nxt_on        = 1'b1;
			end
		end else if (accept) begin
			unique case (req_mode)
				ssdc_pkg::MODE_SHOW: begin
					if (num_bad) begin
						push          = 1'b1;
						push_job.kind = ssdc_pkg::JOB_ERR;
					end
				end
				ssdc_pkg::MODE_LEVEL: begin
					push = 1'b1;
					if (level_bad) begin
						push_job.kind = ssdc_pkg::JOB_ERR;
					end else begin
						nxt_level     = req.value[ssdc_pkg::LEVEL_W-1:0];
						push_job.code = ssdc_pkg::CMD_DISP_ON
							| 8'(req.value[ssdc_pkg::LEVEL_W-1:0]);
					end
				end
				ssdc_pkg::MODE_ON: begin
					push   = 1'b1;
					nxt_on = 1'b1;
				end
				ssdc_pkg::MODE_OFF: begin
					push          = 1'b1;
					nxt_on        = 1'b0;
					push_job.code = ssdc_pkg::CMD_DISP_OFF;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
		push_job.status.number = nxt_num;
		push_job.status.level  = nxt_level;
		push_job.status.on     = nxt_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q  <= 1'b0;
			cnt_q   <= '0;
			num_q   <= '0;
			level_q <= '0;
			on_q    <= 1'b0;
		end else begin
			if (push) begin
				num_q   <= nxt_num;
				level_q <= nxt_level;
				on_q    <= nxt_on;
			end
			if (conv_q) begin
				if (!cnt_done) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (!q_full) begin
					conv_q <= 1'b0;
				end
			end else if (accept && req_mode == ssdc_pkg::MODE_SHOW && !num_bad) begin
				conv_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!conv_q && accept) begin
			rest_q <= req.value;
			val_q  <= req.value;
		end else if (conv_q && !cnt_done) begin
			rest_q <= quot;
			digs_q <= {rem_full[3:0], digs_q[ssdc_pkg::DIG_W-1:4]};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ssdc_queue.sv =====
`default_nettype none

module ssdc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ssdc_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output ssdc_pkg::job_t      head_job
);

	ssdc_pkg::job_t             mem_q [ssdc_pkg::QDEPTH];
	logic [ssdc_pkg::QP_W-1:0]  wr_q;
	logic [ssdc_pkg::QP_W-1:0]  rd_q;
	logic [ssdc_pkg::QC_W-1:0]  cnt_q;
	logic                       do_push;
	logic                       do_pop;

	assign full       = cnt_q == ssdc_pkg::QC_W'(ssdc_pkg::QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_job   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == ssdc_pkg::QP_W'(ssdc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == ssdc_pkg::QP_W'(ssdc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ssdc_back.sv =====
`default_nettype none

module ssdc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire ssdc_pkg::job_t head_job,
	output logic                pop,
	ssdc_rsp_if.source          rsp
);

	logic                           busy_q;
	ssdc_pkg::job_t                 job_q;
	logic [ssdc_pkg::IDX_W-1:0]     idx_q;
	logic [7:0]                     addr_q;
	logic [ssdc_pkg::DIG_W-1:0]     digs_q;

	logic                           valid_q;
	logic [7:0]                     byte_q;
	logic                           fs_q;
	logic                           fe_q;
	logic                           last_q;
	logic                           err_q;
	ssdc_pkg::status_t              stat_q;

	logic                           adv;
	logic                           emit;
	logic                           done;
	logic [7:0]                     nb;
	logic                           nfs;
	logic                           nfe;
	logic                           nlast;
	logic                           nerr;
	logic                           seg_step;

	assign adv  = !valid_q || rsp.ready;
	assign emit = busy_q && adv;
	assign done = emit && nlast;
	assign pop  = head_valid && (!busy_q || done);

	always_comb begin
		nb       = job_q.code;
		nfs      = 1'b1;
		nfe      = 1'b1;
		nlast    = 1'b1;
		nerr     = 1'b0;
		seg_step = 1'b0;
		unique case (job_q.kind)
			ssdc_pkg::JOB_ERR: begin
				nb   = '0;
				nfs  = 1'b0;
				nfe  = 1'b0;
				nerr = 1'b1;
			end
			ssdc_pkg::JOB_BYTE: begin
				nb = job_q.code;
			end
			ssdc_pkg::JOB_NUM: begin
				nlast = 1'b0;
				priority if (idx_q == '0) begin
					nb = ssdc_pkg::CMD_MODE;
				end else if (idx_q == ssdc_pkg::IDX_W'(1)) begin
					nb = ssdc_pkg::CMD_FIXED;
				end else if (idx_q == ssdc_pkg::IDX_W'(ssdc_pkg::NUM_BYTES - 1)) begin
					nb    = ssdc_pkg::CMD_DISP_ON;
					nlast = 1'b1;
				end else if (!idx_q[0]) begin
					nb  = addr_q;
					nfe = 1'b0;
				end else begin
					nb       = ssdc_pkg::seg_code(digs_q[ssdc_pkg::DIG_W-1 -: 4]);
					nfs      = 1'b0;
					seg_step = 1'b1;
				end
			end
			default: begin
				nb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= head_job;
			addr_q <= ssdc_pkg::ADDR_BASE;
			digs_q <= head_job.digits;
		end else if (emit && seg_step) begin
			addr_q <= addr_q + ssdc_pkg::ADDR_STEP;
			digs_q <= digs_q << 4;
		end
		if (emit) begin
			byte_q <= nb;
			fs_q   <= nfs;
			fe_q   <= nfe;
			last_q <= nlast;
			err_q  <= nerr;
			stat_q <= job_q.status;
		end
	end

	assign rsp.valid           = valid_q;
	assign rsp.out_byte        = byte_q;
	assign rsp.frame_start     = fs_q;
	assign rsp.frame_end       = fe_q;
	assign rsp.last            = last_q;
	assign rsp.error           = err_q;
	assign rsp.shown_number    = stat_q.number;
	assign rsp.brightness      = stat_q.level;
	assign rsp.display_enabled = stat_q.on;

endmodule

`default_nettype wire

// ===== hw/rtl/seven_segment_display_commander.sv =====
// channel  dir  handshake    payload
// req      in   valid/ready  mode[1:0], value[13:0]
// rsp      out  valid/ready  out_byte[7:0], frame_start, frame_end, last, error,
//                            shown_number[13:0], brightness[2:0], display_enabled
//
// show-number request: the front splits the digits one per cycle through the
// divide-by-ten multiplier, then the back sends 2*DIGITS+3 bytes (11 at four digits),
// one per cycle while rsp is ready; every other request gives one byte.
// the back emits at most one byte a cycle from a two-entry job queue.
// reset clears shown number, brightness, enable flag and all valid state.
// a stalled rsp holds its byte; req is held off while digits are split or the queue is full.
`default_nettype none

module seven_segment_display_commander (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssdc_req_if.sink   req,
	ssdc_rsp_if.source rsp
);

	ssdc_pkg::job_t push_job;
	ssdc_pkg::job_t head_job;
	logic           push;
	logic           full;
	logic           pop;
	logic           head_valid;

	ssdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_full   (full),
		.push_job (push_job),
		.push     (push)
	);

	ssdc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ssdc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ssdc_checker.sv =====
`default_nettype none

module ssdc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [7:0]  out_byte,
	input wire logic        frame_start,
	input wire logic        frame_end,
	input wire logic        last,
	input wire logic        error,
	input wire logic [13:0] shown_number,
	input wire logic        display_enabled
);

	// stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last))
		else $error("rsp transaction changed while stalled");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error |-> last && out_byte == 8'h00 && !frame_start && !frame_end)
		else $error("error transaction carries a byte");

	a_num: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(shown_number) < 32'(ssdc_pkg::NUM_LIMIT))
		else $error("shown number out of range");

	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !error && out_byte == ssdc_pkg::CMD_DISP_OFF |-> !display_enabled)
		else $error("display off byte with display enabled");

	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !error && !last |-> display_enabled && (frame_start || frame_end))
		else $error("number sequence byte without display enabled or strobe");

endmodule

bind seven_segment_display_commander ssdc_checker u_ssdc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.out_byte        (rsp.out_byte),
	.frame_start     (rsp.frame_start),
	.frame_end       (rsp.frame_end),
	.last            (rsp.last),
	.error           (rsp.error),
	.shown_number    (rsp.shown_number),
	.display_enabled (rsp.display_enabled)
);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

import ssdc_pkg::*;

typedef struct {
	logic [7:0]  out_byte;
	logic        frame_start;
	logic        frame_end;
	logic        last;
	logic        error;
	logic [13:0] shown_number;
	logic [2:0]  brightness;
	logic        display_enabled;
} led_frame_t;

class display_ledger;
	logic [13:0] number;
	logic [2:0]  level;
	logic        lit;
	logic [7:0]  seg_lut [10];
	led_frame_t  pending_frames [$];
	int          mismatch_count;

	function new();
		number = '0;
		level = '0;
		lit = 1'b0;
		mismatch_count = 0;
		seg_lut = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
	endfunction

	function led_frame_t make_frame(logic [7:0] b, logic fs, logic fe, logic lst, logic err);
		led_frame_t f;
		f.out_byte = b;
		f.frame_start = fs;
		f.frame_end = fe;
		f.last = lst;
		f.error = err;
		f.shown_number = '0;
		f.brightness = '0;
		f.display_enabled = 1'b0;
		return f;
	endfunction

	// works out the byte frames of one request and moves the display state on
	function void note_request(mode_t m, logic [13:0] v);
		led_frame_t burst [$];
		led_frame_t f;
		logic [3:0] dig [DIGITS];
		int unsigned rest;
		logic [7:0] addr;
		case (m)
			MODE_SHOW: begin
				if (v >= NUM_LIMIT) begin
					burst.push_back(make_frame(8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
				end else begin
					rest = v;
					for (int i = DIGITS - 1; i >= 0; i--) begin
						dig[i] = 4'(rest % 10);
						rest = rest / 10;
					end
					burst.push_back(make_frame(CMD_MODE, 1'b1, 1'b1, 1'b0, 1'b0));
					burst.push_back(make_frame(CMD_FIXED, 1'b1, 1'b1, 1'b0, 1'b0));
					addr = ADDR_BASE;
					for (int i = 0; i < DIGITS; i++) begin
						burst.push_back(make_frame(addr, 1'b1, 1'b0, 1'b0, 1'b0));
						burst.push_back(make_frame(seg_lut[dig[i]], 1'b0, 1'b1, 1'b0, 1'b0));
						addr = addr + ADDR_STEP;
					end
					burst.push_back(make_frame(CMD_DISP_ON, 1'b1, 1'b1, 1'b1, 1'b0));
					number = v;
					lit = 1'b1;
				end
			end
			MODE_LEVEL: begin
				if (v > 14'd7) begin
					burst.push_back(make_frame(8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
				end else begin
					level = v[2:0];
					burst.push_back(make_frame(CMD_DISP_ON | {5'b0, v[2:0]},
						1'b1, 1'b1, 1'b1, 1'b0));
				end
			end
			MODE_ON: begin
				lit = 1'b1;
				burst.push_back(make_frame(CMD_DISP_ON, 1'b1, 1'b1, 1'b1, 1'b0));
			end
			default: begin
				lit = 1'b0;
				burst.push_back(make_frame(CMD_DISP_OFF, 1'b1, 1'b1, 1'b1, 1'b0));
			end
		endcase
		// status reflects the state after the whole request
		foreach (burst[k]) begin
			f = burst[k];
			f.shown_number = number;
			f.brightness = level;
			f.display_enabled = lit;
			pending_frames.push_back(f);
		end
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task cmp_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want) begin
			report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		end
	endtask

	task check_result(led_frame_t got);
		led_frame_t want;
		if (pending_frames.size() == 0) begin
			report($sformatf("byte 0x%0h with no transaction outstanding", got.out_byte));
			return;
		end
		want = pending_frames.pop_front();
		cmp_field("out_byte", 16'(got.out_byte), 16'(want.out_byte));
		cmp_field("frame_start", 16'(got.frame_start), 16'(want.frame_start));
		cmp_field("frame_end", 16'(got.frame_end), 16'(want.frame_end));
		cmp_field("last", 16'(got.last), 16'(want.last));
		cmp_field("error", 16'(got.error), 16'(want.error));
		cmp_field("shown_number", 16'(got.shown_number), 16'(want.shown_number));
		cmp_field("brightness", 16'(got.brightness), 16'(want.brightness));
		cmp_field("display_enabled", 16'(got.display_enabled), 16'(want.display_enabled));
	endtask
endclass

module tb;
	logic clk;
	logic arst_n;
	logic tx_calm;
	logic rx_calm;

	display_ledger ledger;

	ssdc_req_if req ();
	ssdc_rsp_if rsp ();

	seven_segment_display_commander u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			ledger.note_request(mode_t'(req.mode), req.value);
		end
	end

	always @(posedge clk) begin : rsp_monitor
		led_frame_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.out_byte = rsp.out_byte;
			got.frame_start = rsp.frame_start;
			got.frame_end = rsp.frame_end;
			got.last = rsp.last;
			got.error = rsp.error;
			got.shown_number = rsp.shown_number;
			got.brightness = rsp.brightness;
			got.display_enabled = rsp.display_enabled;
			ledger.check_result(got);
		end
	end

	// byte sink with random back-pressure
	initial begin : byte_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 18);
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
		end
	end

	task send_request(mode_t m, logic [13:0] v);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.value <= v;
		do @(posedge clk); while (!(req.valid && req.ready));
	endtask

	task send_random_request();
		int pick;
		int r;
		mode_t m;
		logic [13:0] v;
		pick = $urandom_range(0, 99);
		r = $urandom_range(0, 19);
		if (pick < 45) begin
			m = MODE_SHOW;
			if (r == 0) v = 14'($urandom_range(10000, 16383));
			else if (r == 1) v = 14'd9999;
			else if (r == 2) v = 14'd0;
			else v = 14'($urandom_range(0, 9999));
		end else if (pick < 70) begin
			m = MODE_LEVEL;
			if (r < 3) v = 14'($urandom_range(8, 16383));
			else v = 14'($urandom_range(0, 7));
		end else if (pick < 85) begin
			m = MODE_ON;
			v = 14'($urandom_range(0, 16383));
		end else begin
			m = MODE_OFF;
			v = 14'($urandom_range(0, 16383));
		end
		send_request(m, v);
	endtask

	initial begin : main
		int n;
		ledger = new();
		arst_n = 1'b0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		req.valid = 1'b0;
		req.mode = MODE_SHOW;
		req.value = '0;
		rsp.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every request kind, rejected values
		send_request(MODE_SHOW, 14'd0);
		send_request(MODE_SHOW, 14'd9999);
		send_request(MODE_SHOW, 14'd10000);
		send_request(MODE_SHOW, 14'd16383);
		send_request(MODE_SHOW, 14'd1234);
		send_request(MODE_SHOW, 14'd5678);
		send_request(MODE_OFF, 14'd16383);
		send_request(MODE_LEVEL, 14'd7);
		send_request(MODE_LEVEL, 14'd8);
		send_request(MODE_LEVEL, 14'd16383);
		send_request(MODE_LEVEL, 14'd0);
		send_request(MODE_ON, 14'd0);
		send_request(MODE_OFF, 14'd0);
		send_request(MODE_LEVEL, 14'd5);
		send_request(MODE_ON, 14'd16383);
		send_request(MODE_OFF, 14'd9);
		send_request(MODE_SHOW, 14'd42);
		send_request(MODE_SHOW, 14'd8086);
		send_request(MODE_LEVEL, 14'd3);

		for (int k = 0; k < 270; k++) begin
			if (k % 25 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			send_random_request();
		end
		req.valid <= 1'b0;

		n = 0;
		while (ledger.pending_frames.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (30) @(posedge clk);
		if (ledger.pending_frames.size() != 0) begin
			ledger.report($sformatf("%0d bytes never arrived", ledger.pending_frames.size()));
		end

		if (ledger.mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

`default_nettype wire
